FILE: hdl/brsc_pkg.sv
// Package for the banker's request safety check unit.
// Holds sizes, reset counts, operation, status and kind codes, the row type and the sequencer state type.
// No dependencies.
package brsc_pkg;

  localparam int MAX_PROCESSES = 16;
  localparam int MAX_RESOURCES = 16;
  localparam int COUNT_WIDTH   = 16;

  localparam int PROC_W = 4;
  localparam int RES_W  = 4;
  localparam int OP_W   = 3;
  localparam int CFG_W  = 5;
  localparam int STAT_W = 2;
  localparam int WORK_W = COUNT_WIDTH + 5;
  localparam int CNT_W  = $clog2(MAX_PROCESSES + 1);
  localparam int ROW_AW = $clog2(MAX_PROCESSES);
  localparam int ROW_W  = MAX_RESOURCES * COUNT_WIDTH;
  localparam int MEM_W  = 2 * ROW_W;

  localparam logic [CFG_W-1:0] NP_RESET = CFG_W'(5);
  localparam logic [CFG_W-1:0] NR_RESET = CFG_W'(3);

  localparam logic [OP_W-1:0] OP_LOAD_ALLOC = OP_W'(0);
  localparam logic [OP_W-1:0] OP_LOAD_MAX   = OP_W'(1);
  localparam logic [OP_W-1:0] OP_LOAD_AVAIL = OP_W'(2);
  localparam logic [OP_W-1:0] OP_LOAD_REQ   = OP_W'(3);
  localparam logic [OP_W-1:0] OP_SUBMIT     = OP_W'(4);

  localparam logic [STAT_W-1:0] STAT_REJECT = STAT_W'(0);
  localparam logic [STAT_W-1:0] STAT_SAFE   = STAT_W'(1);
  localparam logic [STAT_W-1:0] STAT_UNSAFE = STAT_W'(2);

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_SEQ    = 1'b1;

  typedef logic [MAX_RESOURCES-1:0][COUNT_WIDTH-1:0] row_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CHECK,
    ST_SCAN_RD,
    ST_EVAL,
    ST_EMIT_STAT,
    ST_EMIT_SEQ
  } state_t;

endpackage

FILE: hdl/brsc_in_if.sv
// Input channel of the banker's request safety check unit.
// Carries one operation word per handshake. Depends on brsc_pkg.
interface brsc_in_if;
  logic                          valid;
  logic                          ready;
  logic [brsc_pkg::OP_W-1:0]     operation;
  logic [brsc_pkg::PROC_W-1:0]   process;
  logic [brsc_pkg::RES_W-1:0]    resource;
  logic [brsc_pkg::COUNT_WIDTH-1:0] value;

  modport source (output valid, operation, process, resource, value, input ready);
  modport sink (input valid, operation, process, resource, value, output ready);
endinterface

FILE: hdl/brsc_out_if.sv
// Result channel of the banker's request safety check unit.
// Carries one status or sequence word per handshake. Depends on brsc_pkg.
interface brsc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [brsc_pkg::STAT_W-1:0] status;
  logic [brsc_pkg::PROC_W-1:0] position;
  logic [brsc_pkg::PROC_W-1:0] sequence_process;
  logic                        last;

  modport source (output valid, kind, status, position, sequence_process, last, input ready);
  modport sink (input valid, kind, status, position, sequence_process, last, output ready);
endinterface

FILE: hdl/bankers_request_safety_check_unit.sv
// Banker's algorithm request check with safety test.
// Words enter on "requests": loads of the allocation and maximum tables, of the
// available vector and of the request vector give no result; a submit checks the
// loaded request for one process, and if it passes commits it and runs the safety check.
// Each submit gives one status word on "results"; a safe outcome is followed by
// one sequence word per process, the final one with last set.
// A table load is a read-modify-write of one row of the table RAM; vector loads
// are taken in the idle state. A submit checks the request, then visits rows, up
// to num_processes passes over num_processes rows; each visit reads one row and
// compares all resources of the row in parallel. Results sit in an output
// register; a new word is loaded as the receiver takes the previous one. While
// the receiver stalls, no words are taken until the final result word is
// registered; after that, loads are taken and a submit waits for it to drain.
// Reset (rst, synchronous) clears the row valid bits so every table row reads as
// zero, clears the vectors and sets the counts to 5 processes and 3 resources.
// Counts are written over the APB port at byte addresses 0 and 4; the user must
// write them only while the block is idle, which the block itself does not enforce.
// Depends on brsc_pkg, brsc_in_if, brsc_out_if and brsc_ram.
module bankers_request_safety_check_unit (
  input  logic        clk,
  input  logic        rst,
  brsc_in_if.sink     requests,
  brsc_out_if.source  results,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NP = brsc_pkg::MAX_PROCESSES;
  localparam int NR = brsc_pkg::MAX_RESOURCES;
  localparam int CW = brsc_pkg::COUNT_WIDTH;

  brsc_pkg::state_t state, state_next;

  logic [brsc_pkg::CFG_W-1:0] cfg_np, cfg_nr;
  logic [brsc_pkg::CNT_W-1:0] np;
  logic [brsc_pkg::CFG_W-1:0] nr;

  logic [NP-1:0]              row_valid;
  logic                       rd_hit;
  logic [CW-1:0]              avail [NR];
  logic [CW-1:0]              reqv [NR];
  logic [brsc_pkg::WORK_W-1:0] work [NR];
  logic [NP-1:0]              finished;
  logic [brsc_pkg::PROC_W-1:0] order [NP];
  logic [brsc_pkg::CNT_W-1:0] count;
  logic [brsc_pkg::PROC_W-1:0] idx;
  logic                       found;
  logic [brsc_pkg::STAT_W-1:0] status_q;
  logic [brsc_pkg::PROC_W-1:0] pos;

  logic [brsc_pkg::OP_W-1:0]   op_q;
  logic [brsc_pkg::PROC_W-1:0] proc_q;
  logic [brsc_pkg::RES_W-1:0]  res_q;
  logic [CW-1:0]               val_q;

  logic                        o_valid;
  logic                        o_kind;
  logic [brsc_pkg::STAT_W-1:0] o_status;
  logic [brsc_pkg::PROC_W-1:0] o_pos;
  logic [brsc_pkg::PROC_W-1:0] o_seq;
  logic                        o_last;

  logic                        ram_we;
  logic [brsc_pkg::ROW_AW-1:0] ram_waddr, ram_raddr;
  logic [brsc_pkg::MEM_W-1:0]  ram_wdata, ram_rdata;

  brsc_pkg::row_t alloc_row, max_row, load_alloc, load_max, commit_alloc;
  logic [NR-1:0]  in_use;
  logic           req_ok, fits, take, slot_free, accept;
  logic [brsc_pkg::CNT_W-1:0] count_next;
  logic           found_next;

  // Table RAM: allocation rows in the low half, maximum rows in the high half.
  brsc_ram #(.WIDTH(brsc_pkg::MEM_W), .DEPTH(NP)) u_tables (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Counts clamped to the table size.
  assign np = (cfg_np > brsc_pkg::CFG_W'(NP)) ? brsc_pkg::CNT_W'(NP)
                                               : brsc_pkg::CNT_W'(cfg_np);
  assign nr = (cfg_nr > brsc_pkg::CFG_W'(NR)) ? brsc_pkg::CFG_W'(NR) : cfg_nr;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = paddr[2] ? {{(32 - brsc_pkg::CFG_W){1'b0}}, cfg_nr}
                           : {{(32 - brsc_pkg::CFG_W){1'b0}}, cfg_np};

  // A row never written reads as zero.
  assign alloc_row = rd_hit ? brsc_pkg::row_t'(ram_rdata[brsc_pkg::ROW_W-1:0])
                            : '0;
  assign max_row   = rd_hit ? brsc_pkg::row_t'(ram_rdata[brsc_pkg::MEM_W-1:brsc_pkg::ROW_W])
                            : '0;

  // Row compares, one lane per resource.
  always_comb begin
    req_ok = 1'b1;
    fits   = 1'b1;
    load_alloc   = alloc_row;
    load_max     = max_row;
    commit_alloc = alloc_row;
    for (int j = 0; j < NR; j++) begin
      in_use[j] = (brsc_pkg::CFG_W'(j) < nr);
      if (in_use[j]) begin
        if (reqv[j] > avail[j]) begin
          req_ok = 1'b0;
        end
        if ({1'b0, reqv[j]} + {1'b0, alloc_row[j]} > {1'b0, max_row[j]}) begin
          req_ok = 1'b0;
        end
        if (brsc_pkg::WORK_W'(max_row[j]) >
            brsc_pkg::WORK_W'(alloc_row[j]) + work[j]) begin
          fits = 1'b0;
        end
        commit_alloc[j] = alloc_row[j] + reqv[j];
      end
    end
    load_alloc[res_q] = val_q;
    load_max[res_q]   = val_q;
  end

  assign take       = !finished[idx] && fits;
  assign count_next = count + brsc_pkg::CNT_W'(take);
  assign found_next = found | take;
  assign slot_free  = !o_valid || results.ready;
  assign accept     = requests.valid && requests.ready;

  // Sequencer next state and RAM control.
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = proc_q;
    ram_wdata  = {max_row, alloc_row};
    ram_raddr  = idx;
    requests.ready = (state == brsc_pkg::ST_IDLE);
    case (state)
      brsc_pkg::ST_IDLE: begin
        ram_raddr = requests.process;
        if (requests.valid) begin
          case (requests.operation)
            brsc_pkg::OP_LOAD_ALLOC, brsc_pkg::OP_LOAD_MAX: begin
              state_next = brsc_pkg::ST_LOAD;
            end
            brsc_pkg::OP_SUBMIT: begin
              if (brsc_pkg::CNT_W'(requests.process) >= np) begin
                state_next = brsc_pkg::ST_EMIT_STAT;
              end else begin
                state_next = brsc_pkg::ST_CHECK;
              end
            end
            default: state_next = brsc_pkg::ST_IDLE;
          endcase
        end
      end
      brsc_pkg::ST_LOAD: begin
        ram_we = 1'b1;
        if (op_q == brsc_pkg::OP_LOAD_ALLOC) begin
          ram_wdata = {max_row, load_alloc};
        end else begin
          ram_wdata = {load_max, alloc_row};
        end
        state_next = brsc_pkg::ST_IDLE;
      end
      brsc_pkg::ST_CHECK: begin
        if (req_ok) begin
          ram_we     = 1'b1;
          ram_wdata  = {max_row, commit_alloc};
          state_next = brsc_pkg::ST_SCAN_RD;
        end else begin
          state_next = brsc_pkg::ST_EMIT_STAT;
        end
      end
      brsc_pkg::ST_SCAN_RD: begin
        state_next = brsc_pkg::ST_EVAL;
      end
      brsc_pkg::ST_EVAL: begin
        if (brsc_pkg::CNT_W'(idx) == np - brsc_pkg::CNT_W'(1)) begin
          if (count_next == np || !found_next) begin
            state_next = brsc_pkg::ST_EMIT_STAT;
          end else begin
            state_next = brsc_pkg::ST_SCAN_RD;
          end
        end else begin
          state_next = brsc_pkg::ST_SCAN_RD;
        end
      end
      brsc_pkg::ST_EMIT_STAT: begin
        if (slot_free) begin
          state_next = (status_q == brsc_pkg::STAT_SAFE) ? brsc_pkg::ST_EMIT_SEQ
                                                          : brsc_pkg::ST_IDLE;
        end
      end
      brsc_pkg::ST_EMIT_SEQ: begin
        if (slot_free && brsc_pkg::CNT_W'(pos) == np - brsc_pkg::CNT_W'(1)) begin
          state_next = brsc_pkg::ST_IDLE;
        end
      end
      default: state_next = brsc_pkg::ST_IDLE;
    endcase
  end

  // State register, configuration and control flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= brsc_pkg::ST_IDLE;
      cfg_np    <= brsc_pkg::NP_RESET;
      cfg_nr    <= brsc_pkg::NR_RESET;
      row_valid <= '0;
      finished  <= '0;
      o_valid   <= 1'b0;
      for (int j = 0; j < NR; j++) begin
        avail[j] <= '0;
        reqv[j]  <= '0;
      end
    end else begin
      state <= state_next;
      if (psel && penable && pwrite) begin
        if (paddr[2]) begin
          cfg_nr <= pwdata[brsc_pkg::CFG_W-1:0];
        end else begin
          cfg_np <= pwdata[brsc_pkg::CFG_W-1:0];
        end
      end
      if (ram_we) begin
        row_valid[ram_waddr] <= 1'b1;
      end
      if (accept && requests.operation == brsc_pkg::OP_LOAD_AVAIL) begin
        avail[requests.resource] <= requests.value;
      end
      if (accept && requests.operation == brsc_pkg::OP_LOAD_REQ) begin
        reqv[requests.resource] <= requests.value;
      end
      if (state == brsc_pkg::ST_CHECK && req_ok) begin
        finished <= '0;
        for (int j = 0; j < NR; j++) begin
          if (in_use[j]) begin
            avail[j] <= avail[j] - reqv[j];
          end
        end
      end
      if (state == brsc_pkg::ST_EVAL && take) begin
        finished[idx] <= 1'b1;
      end
      if (results.ready) begin
        o_valid <= 1'b0;
      end
      if ((state == brsc_pkg::ST_EMIT_STAT || state == brsc_pkg::ST_EMIT_SEQ) &&
          slot_free) begin
        o_valid <= 1'b1;
      end
    end
  end

  // Datapath registers: captured word, scan counters, work vector, results.
  always_ff @(posedge clk) begin
    rd_hit <= row_valid[ram_raddr];
    if (accept) begin
      op_q     <= requests.operation;
      proc_q   <= requests.process;
      res_q    <= requests.resource;
      val_q    <= requests.value;
      status_q <= brsc_pkg::STAT_REJECT;
    end
    case (state)
      brsc_pkg::ST_CHECK: begin
        count <= '0;
        idx   <= '0;
        found <= 1'b0;
        pos   <= '0;
        for (int j = 0; j < NR; j++) begin
          work[j] <= brsc_pkg::WORK_W'(avail[j] - reqv[j]);
        end
      end
      brsc_pkg::ST_EVAL: begin
        if (take) begin
          order[count[brsc_pkg::PROC_W-1:0]] <= idx;
          for (int j = 0; j < NR; j++) begin
            work[j] <= work[j] + brsc_pkg::WORK_W'(alloc_row[j]);
          end
        end
        count <= count_next;
        if (brsc_pkg::CNT_W'(idx) == np - brsc_pkg::CNT_W'(1)) begin
          idx   <= '0;
          found <= 1'b0;
          if (count_next == np) begin
            status_q <= brsc_pkg::STAT_SAFE;
          end else if (!found_next) begin
            status_q <= brsc_pkg::STAT_UNSAFE;
          end
        end else begin
          idx   <= idx + brsc_pkg::PROC_W'(1);
          found <= found_next;
        end
      end
      brsc_pkg::ST_EMIT_STAT: begin
        if (slot_free) begin
          o_kind   <= brsc_pkg::KIND_STATUS;
          o_status <= status_q;
          o_pos    <= '0;
          o_seq    <= '0;
          o_last   <= (status_q != brsc_pkg::STAT_SAFE);
          pos      <= '0;
        end
      end
      brsc_pkg::ST_EMIT_SEQ: begin
        if (slot_free) begin
          o_kind   <= brsc_pkg::KIND_SEQ;
          o_status <= brsc_pkg::STAT_SAFE;
          o_pos    <= pos;
          o_seq    <= order[pos];
          o_last   <= (brsc_pkg::CNT_W'(pos) == np - brsc_pkg::CNT_W'(1));
          pos      <= pos + brsc_pkg::PROC_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign results.valid            = o_valid;
  assign results.kind             = o_kind;
  assign results.status           = o_status;
  assign results.position         = o_pos;
  assign results.sequence_process = o_seq;
  assign results.last             = o_last;

  // During the scan the finished marks count the processes placed in the sequence.
  a_count_marks: assert property (@(posedge clk) disable iff (rst)
    (state == brsc_pkg::ST_SCAN_RD || state == brsc_pkg::ST_EVAL) |->
      ($countones(finished) == 32'(count)))
    else $error("finished marks disagree with sequence count");

  // Sequence words only follow a safe outcome.
  a_seq_safe: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_kind == brsc_pkg::KIND_SEQ) |-> (o_status == brsc_pkg::STAT_SAFE))
    else $error("sequence word without safe status");

  // Reset leaves every table row reading as zero.
  a_reset_rows: assert property (@(posedge clk)
    $past(rst) |-> (row_valid == '0))
    else $error("row valid bits not cleared by reset");

endmodule

FILE: hdl/brsc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module brsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
